// ----- hw/rtl/tgl_pkg.sv -----
// ----------------------------------------------------------------------------
// tgl_pkg
// Shared types and constants of the text grid layout block.
// ----------------------------------------------------------------------------
package tgl_pkg;

  localparam int unsigned COL_LIMIT_DEF = 256;
  localparam int unsigned ROW_LIMIT_DEF = 1024;
  localparam int unsigned TAB_WIDTH_DEF = 4;

  localparam int unsigned ColW  = 9;
  localparam int unsigned RowW  = 11;
  localparam int unsigned AddrW = 18;
  localparam int unsigned CharW = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 11;

  localparam logic [CharW-1:0] CH_END       = 8'd0;
  localparam logic [CharW-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CharW-1:0] CH_TAB       = 8'd9;
  localparam logic [CharW-1:0] CH_NEWLINE   = 8'd10;

  localparam logic [CfgIdxW-1:0] CFG_MAX_COLS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_ROWS = 2'd1;

  localparam logic [ColW-1:0] MAX_COLS_RST = 9'd256;
  localparam logic [RowW-1:0] MAX_ROWS_RST = 11'd1024;

  typedef struct packed {
    logic             start_req;
    logic [CharW-1:0] character;
  } item_t;

  typedef struct packed {
    logic             stopped;
    logic [RowW-1:0]  highest_row;
    logic [ColW-1:0]  widest_column;
    logic [CharW-1:0] cell_char;
    logic [AddrW-1:0] cell_address;
    logic             write_enable;
  } result_t;

endpackage

// ----- hw/rtl/text_grid_layout.sv -----
// ----------------------------------------------------------------------------
// text_grid_layout
// Lays a byte stream into a row-by-column text grid and reports each write.
// ----------------------------------------------------------------------------
// One result per input byte, one byte per clock sustained while the output
// is not stalled. A byte is held in the input register, then the cursor
// step, the row*cols+col address multiply and the wrap and stop checks run
// combinationally into the result register. The cursor state updates in
// the same cycle as the result register loads, so consecutive bytes follow
// each other without a gap. Configuration writes are taken every cycle and
// must only be made while the block is idle.
module text_grid_layout #(
  parameter int unsigned COL_LIMIT = tgl_pkg::COL_LIMIT_DEF,
  parameter int unsigned ROW_LIMIT = tgl_pkg::ROW_LIMIT_DEF,
  parameter int unsigned TAB_WIDTH = tgl_pkg::TAB_WIDTH_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [tgl_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tgl_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  input  logic [7:0]                   s_axis_tdata_i,  // character
  input  logic [0:0]                   s_axis_tuser_i,  // start_req
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // cell_address, cell_char, widest_column, highest_row, stopped, zero pad
  output logic [47:0]                  m_axis_tdata_o,
  output logic [0:0]                   m_axis_tuser_o   // write_enable
);

  tgl_pkg::item_t   in_item, core_item;
  tgl_pkg::result_t result;
  logic             core_valid, core_ready;

  assign cfg_ready_o = 1'b1;

  assign in_item.start_req = s_axis_tuser_i[0];
  assign in_item.character = s_axis_tdata_i;

  tgl_in_reg u_in_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid_i),
    .ready_o (s_axis_tready_o),
    .item_i  (in_item),
    .valid_o (core_valid),
    .ready_i (core_ready),
    .item_o  (core_item)
  );

  tgl_core #(
    .COL_LIMIT (COL_LIMIT),
    .ROW_LIMIT (ROW_LIMIT),
    .TAB_WIDTH (TAB_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .valid_i     (core_valid),
    .ready_o     (core_ready),
    .item_i      (core_item),
    .valid_o     (m_axis_tvalid_o),
    .ready_i     (m_axis_tready_i),
    .result_o    (result)
  );

  assign m_axis_tuser_o[0] = result.write_enable;
  assign m_axis_tdata_o    = {1'b0, result.stopped, result.highest_row,
                              result.widest_column, result.cell_char,
                              result.cell_address};

endmodule

// ----- hw/rtl/tgl_in_reg.sv -----
// ----------------------------------------------------------------------------
// tgl_in_reg
// Input register stage: holds one item until the layout core takes it.
// ----------------------------------------------------------------------------
module tgl_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  tgl_pkg::item_t item_i,
  output logic          valid_o,
  input  logic          ready_i,
  output tgl_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  tgl_pkg::item_t item_q;

  assign ready_o = !valid_q || ready_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

// ----- hw/rtl/tgl_core.sv -----
// ----------------------------------------------------------------------------
// tgl_core
// Cursor state, configuration registers, layout step and result register.
// ----------------------------------------------------------------------------
module tgl_core #(
  parameter int unsigned COL_LIMIT = tgl_pkg::COL_LIMIT_DEF,
  parameter int unsigned ROW_LIMIT = tgl_pkg::ROW_LIMIT_DEF,
  parameter int unsigned TAB_WIDTH = tgl_pkg::TAB_WIDTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [tgl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tgl_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  tgl_pkg::item_t                item_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output tgl_pkg::result_t              result_o
);

  localparam int unsigned PhaseW = (TAB_WIDTH > 1) ? $clog2(TAB_WIDTH) : 1;
  localparam int unsigned ColW   = tgl_pkg::ColW;
  localparam int unsigned RowW   = tgl_pkg::RowW;
  localparam logic [ColW-1:0] ColTop = '1;
  localparam logic [RowW-1:0] RowTop = '1;

  logic [ColW-1:0]   max_cols_q, max_cols_d;
  logic [RowW-1:0]   max_rows_q, max_rows_d;
  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic [ColW-1:0]   max_col_q, max_col_d;
  logic [RowW-1:0]   max_row_q, max_row_d;
  logic              halted_q, halted_d;
  logic              out_valid_q, out_valid_d;
  tgl_pkg::result_t  result_q, result_d;

  logic              take;
  logic [ColW-1:0]   cols;
  logic [RowW-1:0]   rows;
  logic [ColW-1:0]   b_col, max_col_b, n_col, s_col;
  logic [RowW-1:0]   b_row, max_row_b, n_row;
  logic [PhaseW-1:0] b_phase, n_phase;
  logic              b_halted, halt0, active, wrap;
  logic [ColW:0]     col_sum;
  logic [RowW+ColW-1:0] product;

  assign ready_o = !out_valid_q || ready_i;
  assign take    = valid_i && ready_o;

  always_comb begin
    max_cols_d = max_cols_q;
    max_rows_d = max_rows_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tgl_pkg::CFG_MAX_COLS: max_cols_d = cfg_data_i[ColW-1:0];
        tgl_pkg::CFG_MAX_ROWS: max_rows_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cols = max_cols_q;
    if (max_cols_q == '0) cols = ColW'(1);
    if ({4'b0, max_cols_q} > 13'(COL_LIMIT)) cols = ColW'(COL_LIMIT);
    rows = max_rows_q;
    if (max_rows_q == '0) rows = RowW'(1);
    if ({2'b0, max_rows_q} > 13'(ROW_LIMIT)) rows = RowW'(ROW_LIMIT);
  end

  always_comb begin
    b_col     = item_i.start_req ? '0   : col_q;
    b_row     = item_i.start_req ? '0   : row_q;
    b_phase   = item_i.start_req ? '0   : phase_q;
    max_col_b = item_i.start_req ? '0   : max_col_q;
    max_row_b = item_i.start_req ? '0   : max_row_q;
    b_halted  = item_i.start_req ? 1'b0 : halted_q;

    halt0  = b_halted || (b_row >= rows);
    active = !halt0 && (item_i.character != tgl_pkg::CH_END);

    product = b_row * cols;

    n_row   = b_row;
    n_phase = b_phase;
    col_sum = '0;
    case (item_i.character)
      tgl_pkg::CH_BACKSPACE: begin
        n_col = b_col;
        if (b_col != '0) begin
          n_col   = b_col - ColW'(1);
          n_phase = (b_phase == '0) ? PhaseW'(TAB_WIDTH - 1) : b_phase - PhaseW'(1);
        end
      end
      tgl_pkg::CH_NEWLINE: begin
        n_col   = '0;
        n_row   = (b_row == RowTop) ? RowTop : b_row + RowW'(1);
        n_phase = '0;
      end
      tgl_pkg::CH_TAB: begin
        col_sum = {1'b0, b_col} - (ColW+1)'(b_phase) + (ColW+1)'(TAB_WIDTH);
        n_col   = col_sum[ColW] ? ColTop : col_sum[ColW-1:0];
        n_phase = '0;
      end
      default: begin
        n_col   = (b_col == ColTop) ? ColTop : b_col + ColW'(1);
        n_phase = (b_phase == PhaseW'(TAB_WIDTH - 1)) ? '0 : b_phase + PhaseW'(1);
      end
    endcase

    s_col = n_col;
    wrap  = (n_col >= cols - ColW'(1));

    col_d     = col_q;
    row_d     = row_q;
    phase_d   = phase_q;
    max_col_d = max_col_q;
    max_row_d = max_row_q;
    halted_d  = halted_q;

    result_d = '0;

    if (take) begin
      col_d     = b_col;
      row_d     = b_row;
      phase_d   = b_phase;
      max_col_d = max_col_b;
      max_row_d = max_row_b;
      halted_d  = halt0 || (item_i.character == tgl_pkg::CH_END);
      if (active) begin
        if (s_col > max_col_b) max_col_d = s_col;
        if (n_row > max_row_b) max_row_d = n_row;
        if (wrap) begin
          col_d   = '0;
          row_d   = (n_row == RowTop) ? RowTop : n_row + RowW'(1);
          phase_d = '0;
        end else begin
          col_d   = n_col;
          row_d   = n_row;
          phase_d = n_phase;
        end
        halted_d = (row_d >= rows);
      end
    end

    result_d.write_enable  = active;
    result_d.cell_address  = active ?
                             (product[tgl_pkg::AddrW-1:0] + tgl_pkg::AddrW'(b_col)) : '0;
    result_d.cell_char     = active ? item_i.character : '0;
    result_d.widest_column = max_col_d;
    result_d.highest_row   = max_row_d;
    result_d.stopped       = halted_d;

    out_valid_d = take ? 1'b1 : (ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_cols_q  <= tgl_pkg::MAX_COLS_RST;
      max_rows_q  <= tgl_pkg::MAX_ROWS_RST;
      col_q       <= '0;
      row_q       <= '0;
      phase_q     <= '0;
      max_col_q   <= '0;
      max_row_q   <= '0;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      max_cols_q  <= max_cols_d;
      max_rows_q  <= max_rows_d;
      col_q       <= col_d;
      row_q       <= row_d;
      phase_q     <= phase_d;
      max_col_q   <= max_col_d;
      max_row_q   <= max_row_d;
      halted_q    <= halted_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = result_q;

endmodule

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the text grid layout block. A short directed
// sequence covers control bytes, stop conditions and grid settings at their
// extremes. Random texts follow under a series of grid settings, with bursty
// input, a stalling output and one long output hold-off. Each output transfer
// is checked field by field against a cursor model kept in the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tgl_pkg::*;

  localparam int unsigned IdleLimit  = 2000;
  localparam int unsigned HoldCycles = 200;
  localparam int unsigned NumPhases  = 18;

  class grid_scoreboard;
    logic [ColW-1:0]  max_cols;
    logic [RowW-1:0]  max_rows;
    logic [ColW-1:0]  cur_col;
    logic [RowW-1:0]  cur_row;
    logic [ColW-1:0]  widest;
    logic [RowW-1:0]  highest;
    bit               halted;
    result_t          pending_writes[$];
    int unsigned      mismatches;
    int unsigned      bytes_sent;
    int unsigned      cells_written;
    int unsigned      texts;
    int unsigned      results_seen;
    int unsigned      top_row_seen;
    int unsigned      top_col_seen;

    function new();
      max_cols = MAX_COLS_RST;
      max_rows = MAX_ROWS_RST;
      cur_col  = '0;
      cur_row  = '0;
      widest   = '0;
      highest  = '0;
      halted   = 1'b0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      if (idx == CFG_MAX_COLS) begin
        max_cols = val[ColW-1:0];
      end else if (idx == CFG_MAX_ROWS) begin
        max_rows = val[RowW-1:0];
      end
    endfunction

    function void note_byte(bit start, logic [CharW-1:0] ch);
      int unsigned cols;
      int unsigned rows;
      int unsigned col;
      int unsigned row;
      result_t     r;
      cols = max_cols;
      rows = max_rows;
      if (cols < 1) cols = 1;
      if (cols > COL_LIMIT_DEF) cols = COL_LIMIT_DEF;
      if (rows < 1) rows = 1;
      if (rows > ROW_LIMIT_DEF) rows = ROW_LIMIT_DEF;
      r = '0;
      bytes_sent++;
      if (start) begin
        cur_col = '0;
        cur_row = '0;
        widest  = '0;
        highest = '0;
        halted  = 1'b0;
        texts++;
      end
      if (!halted && cur_row >= rows) halted = 1'b1;
      if (!halted) begin
        if (ch == CH_END) begin
          halted = 1'b1;
        end else begin
          col = cur_col;
          row = cur_row;
          r.write_enable = 1'b1;
          r.cell_char    = ch;
          r.cell_address = AddrW'(row * cols + col);
          case (ch)
            CH_BACKSPACE: begin
              if (col > 0) col = col - 1;
            end
            CH_NEWLINE: begin
              col = 0;
              row = row + 1;
            end
            CH_TAB: begin
              col = (col / TAB_WIDTH_DEF + 1) * TAB_WIDTH_DEF;
            end
            default: begin
              col = col + 1;
            end
          endcase
          if (col > 511) col = 511;
          if (row > 2047) row = 2047;
          if (col > widest) widest = ColW'(col);
          if (row > highest) highest = RowW'(row);
          if (col >= cols - 1) begin
            col = 0;
            row = (row + 1 > 2047) ? 2047 : row + 1;
          end
          if (row >= rows) halted = 1'b1;
          cur_col = ColW'(col);
          cur_row = RowW'(row);
          cells_written++;
          if (widest > top_col_seen) top_col_seen = widest;
          if (highest > top_row_seen) top_row_seen = highest;
        end
      end
      r.widest_column = widest;
      r.highest_row   = highest;
      r.stopped       = halted;
      pending_writes.push_back(r);
    endfunction

    function void check_write(result_t got);
      result_t want;
      if (pending_writes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: we=%0d addr=%0d ch=%0d wc=%0d hr=%0d st=%0d",
                   got.write_enable, got.cell_address, got.cell_char,
                   got.widest_column, got.highest_row, got.stopped);
        end
        return;
      end
      want = pending_writes.pop_front();
      results_seen++;
      if (got.write_enable !== want.write_enable || got.cell_address !== want.cell_address ||
          got.cell_char !== want.cell_char || got.widest_column !== want.widest_column ||
          got.highest_row !== want.highest_row || got.stopped !== want.stopped) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch #%0d: exp we=%0d addr=%0d ch=%0d wc=%0d hr=%0d st=%0d",
                   results_seen, want.write_enable, want.cell_address, want.cell_char,
                   want.widest_column, want.highest_row, want.stopped);
          $display("              got we=%0d addr=%0d ch=%0d wc=%0d hr=%0d st=%0d",
                   got.write_enable, got.cell_address, got.cell_char,
                   got.widest_column, got.highest_row, got.stopped);
        end
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                s_tvalid;
  logic                s_tready;
  logic [7:0]          s_tdata;
  logic [0:0]          s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [47:0]         m_tdata;
  logic [0:0]          m_tuser;

  grid_scoreboard sb;

  int unsigned rx_mode;
  int unsigned tx_mode;
  bit          hold_off;
  bit          rx_on;
  int unsigned rx_run;
  int unsigned burst_left;
  int unsigned idle_cycles;
  int unsigned settings_run;

  text_grid_layout i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (hold_off) begin
      m_tready <= 1'b0;
      repeat (HoldCycles) @(negedge clk_i);
      hold_off = 1'b0;
    end else begin
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 9) >= 3);
        default: begin
          if (rx_run == 0) begin
            rx_on  = !rx_on;
            rx_run = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 8);
          end
          rx_run--;
          m_tready <= rx_on;
        end
      endcase
    end
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        got.write_enable  = m_tuser[0];
        got.cell_address  = m_tdata[17:0];
        got.cell_char     = m_tdata[25:18];
        got.widest_column = m_tdata[34:26];
        got.highest_row   = m_tdata[45:35];
        got.stopped       = m_tdata[46];
        sb.check_write(got);
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IdleLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic push_byte(bit start, logic [7:0] ch);
    if (burst_left == 0) begin
      case (tx_mode)
        0: burst_left = 1000;
        1: burst_left = $urandom_range(1, 16);
        default: burst_left = $urandom_range(1, 4);
      endcase
      if (tx_mode != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, tx_mode == 1 ? 4 : 10)) @(negedge clk_i);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= start;
    do @(posedge clk_i); while (!s_tready);
    sb.note_byte(start, ch);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_writes.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_grid(logic [CfgDataW-1:0] cols_val, logic [CfgDataW-1:0] rows_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAX_COLS;
    cfg_data  <= cols_val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_reg(CFG_MAX_COLS, cols_val);
    @(negedge clk_i);
    cfg_index <= CFG_MAX_ROWS;
    cfg_data  <= rows_val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.set_reg(CFG_MAX_ROWS, rows_val);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
    settings_run++;
  endtask

  function automatic logic [7:0] pick_char(int unsigned style);
    int unsigned p;
    p = $urandom_range(0, 99);
    case (style)
      1: begin
        if (p < 1) return CH_END;
        if (p < 35) return CH_NEWLINE;
        if (p < 45) return CH_TAB;
        if (p < 50) return CH_BACKSPACE;
      end
      2: begin
        if (p < 1) return CH_END;
        if (p < 3) return CH_NEWLINE;
        if (p < 40) return CH_TAB;
        if (p < 45) return CH_BACKSPACE;
      end
      default: begin
        if (p < 2) return CH_END;
        if (p < 8) return CH_NEWLINE;
        if (p < 16) return CH_TAB;
        if (p < 24) return CH_BACKSPACE;
      end
    endcase
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic run_texts(int unsigned target, int unsigned style);
    int unsigned goal;
    int unsigned sent;
    bit          start;
    goal = sb.cells_written + target;
    sent = 0;
    while (sb.cells_written < goal && sent < 4 * target) begin
      if (sb.halted) begin
        start = ($urandom_range(0, 3) != 0);
      end else begin
        start = ($urandom_range(0, 39) == 0);
      end
      push_byte(start, pick_char(style));
      sent++;
    end
  endtask

  int unsigned phase_cols [NumPhases];
  int unsigned phase_rows [NumPhases];
  int unsigned phase_style[NumPhases];

  initial begin
    sb         = new();
    rst_ni     = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = CFG_MAX_COLS;
    cfg_data   = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    m_tready   = 1'b0;
    rx_mode    = 0;
    tx_mode    = 0;
    hold_off   = 1'b0;
    rx_on      = 1'b0;
    rx_run     = 0;
    burst_left = 0;
    idle_cycles  = 0;
    settings_run = 0;
    phase_cols  = '{2, 2, 3, 4, 5, 8, 16, 0, 1, 7, 256, 511, 257, 255, 0, 0, 0, 0};
    phase_rows  = '{1, 3, 4, 8, 2, 16, 5, 2, 3, 1023, 1024, 2047, 1025, 0, 0, 0, 0, 0};
    phase_style = '{0, 0, 2, 2, 0, 1, 0, 0, 1, 1, 1, 2, 0, 0, 0, 1, 2, 0};
    for (int i = 14; i < NumPhases; i++) begin
      phase_cols[i] = (i % 2 == 0) ? $urandom_range(2, 40) : $urandom_range(0, 511);
      phase_rows[i] = (i % 2 == 0) ? $urandom_range(1, 20) : $urandom_range(0, 2047);
    end

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    push_byte(1'b1, 8'h41);
    push_byte(1'b0, CH_TAB);
    push_byte(1'b0, CH_BACKSPACE);
    push_byte(1'b0, 8'hFF);
    push_byte(1'b0, CH_NEWLINE);
    push_byte(1'b0, 8'h80);
    push_byte(1'b0, CH_END);
    push_byte(1'b0, 8'h78);
    push_byte(1'b1, CH_BACKSPACE);
    push_byte(1'b0, 8'h01);
    push_byte(1'b0, 8'h7F);
    push_byte(1'b0, CH_NEWLINE);
    push_byte(1'b0, CH_NEWLINE);
    drain();
    set_grid(11'd256, 11'd2);
    push_byte(1'b0, 8'h71);
    push_byte(1'b1, 8'h61);
    push_byte(1'b0, 8'h62);
    push_byte(1'b0, 8'h63);
    drain();
    set_grid(11'd2, 11'd1024);
    push_byte(1'b0, 8'h64);
    drain();
    set_grid(11'd0, 11'd1024);
    push_byte(1'b1, 8'h65);
    push_byte(1'b0, 8'h66);
    drain();
    set_grid(11'd511, 11'd0);
    push_byte(1'b1, 8'h67);
    push_byte(1'b0, CH_NEWLINE);
    drain();
    set_grid(11'h7FF, 11'h7FF);
    push_byte(1'b1, CH_TAB);
    push_byte(1'b0, 8'hAA);
    push_byte(1'b0, 8'h55);
    drain();

    for (int i = 0; i < NumPhases; i++) begin
      rx_mode = i % 3;
      tx_mode = (i / 3) % 3;
      set_grid(CfgDataW'(phase_cols[i]), CfgDataW'(phase_rows[i]));
      if (i == 2) hold_off = 1'b1;
      run_texts(i == 10 ? 300 : 80, phase_style[i]);
      drain();
    end

    rx_mode = 0;
    repeat (8) @(negedge clk_i);
    $display("Ran %0d bytes in %0d texts under %0d grid settings; %0d cells written.",
             sb.bytes_sent, sb.texts, settings_run, sb.cells_written);
    $display("Furthest reach: row %0d, column %0d; %0d results checked.",
             sb.top_row_seen, sb.top_col_seen, sb.results_seen);
    if (sb.mismatches == 0 && sb.pending_writes.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
